// ===== sv/fsds_pkg.sv =====
// Package for the fuzzy steering / dual speed PI block: types, gain tables, rule table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fsds_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_SET_SPEED    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_YAW_SLOWDOWN = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_LEFT_PROP    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_LEFT_INT     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_RIGHT_PROP   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_RIGHT_INT    = 3'd5;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [3:0] {
    OP_BASE   = 4'd0,  // base speed product
    OP_GAINS  = 4'd1,  // fuzzy gain lookup
    OP_EFF_P  = 4'd2,  // off * kp
    OP_EFF_D  = 4'd3,  // d * kd
    OP_SQ     = 4'd4,  // |off| * off
    OP_EFF_P2 = 4'd5,  // sq * kp2
    OP_EFF_Y  = 4'd6,  // yaw * kd2
    OP_TARGET = 4'd7,  // wheel targets and held effort
    OP_ERR    = 4'd8,  // wheel errors
    OP_LP     = 4'd9,
    OP_LI     = 4'd10,
    OP_RP     = 4'd11,
    OP_RI     = 4'd12,
    OP_DRIVE  = 4'd13,
    OP_NONE   = 4'd15
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   steer;
  } dp_cmd_t;

  function automatic logic [2:0] band_of(input logic signed [16:0] v);
    logic [2:0] b;
    begin
      if (v <= -17'sd75)      b = 3'd0;
      else if (v <= -17'sd50) b = 3'd1;
      else if (v <= -17'sd25) b = 3'd2;
      else if (v <= 17'sd25)  b = 3'd3;
      else if (v <= 17'sd50)  b = 3'd4;
      else if (v <= 17'sd75)  b = 3'd5;
      else                    b = 3'd6;
      return b;
    end
  endfunction

  function automatic logic [2:0] rule_of(input logic [2:0] r, input logic [2:0] c);
    logic [20:0] row;
    begin
      case (r)
        3'd0:    row = {3'd3, 3'd3, 3'd5, 3'd6, 3'd6, 3'd6, 3'd6};
        3'd1:    row = {3'd3, 3'd3, 3'd5, 3'd6, 3'd6, 3'd6, 3'd6};
        3'd2:    row = {3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd5, 3'd6};
        3'd3:    row = {3'd1, 3'd1, 3'd1, 3'd3, 3'd4, 3'd5, 3'd5};
        3'd4:    row = {3'd6, 3'd0, 3'd1, 3'd1, 3'd3, 3'd4, 3'd4};
        3'd5:    row = {3'd6, 3'd0, 3'd0, 3'd1, 3'd3, 3'd3, 3'd3};
        default: row = {3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd2, 3'd3};
      endcase
      return row[c*3 +: 3];
    end
  endfunction

  // Gain set {kp, kd, kp2, kd2}, each 20 bits, Q4.16.
  function automatic logic [79:0] gain_set(input logic mid, input logic [1:0] g);
    logic [79:0] s;
    begin
      if (!mid) begin
        case (g)
          2'd0:    s = {20'd27525, 20'd78643, 20'd66, 20'd393};
          2'd1:    s = {20'd29491, 20'd78643, 20'd66, 20'd328};
          2'd2:    s = {20'd31457, 20'd78643, 20'd98, 20'd197};
          default: s = {20'd34079, 20'd81920, 20'd131, 20'd131};
        endcase
      end else begin
        case (g)
          2'd0:    s = {20'd26214, 20'd78643, 20'd66, 20'd197};
          2'd1:    s = {20'd28180, 20'd78643, 20'd66, 20'd197};
          2'd2:    s = {20'd30802, 20'd78643, 20'd66, 20'd197};
          default: s = {20'd32768, 20'd78643, 20'd66, 20'd66};
        endcase
      end
      return s;
    end
  endfunction

endpackage
`default_nettype wire

// ===== sv/fsds_ctrl.sv =====
// Controller: one-hot sequencer stepping the shared-multiplier datapath through a tick.
// Depends on fsds_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fsds_ctrl #(
  parameter int unsigned SteerDivider = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_tvalid_i,
  output logic               s_tready_o,
  output logic               m_tvalid_o,
  input  wire logic          m_tready_i,
  output fsds_pkg::dp_cmd_t  cmd_o
);
  import fsds_pkg::*;

  localparam int unsigned PhW = (SteerDivider > 1) ? $clog2(SteerDivider) : 1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_OUT  = 4'b0100,
    ST_WAIT = 4'b1000
  } state_e;

  state_e         state_q, state_d;
  dp_op_e         op_q, op_d;
  logic           steer_q, steer_d;
  logic [PhW-1:0] phase_q, phase_d;
  logic           out_v_q, out_v_d;
  logic           fire;

  assign fire = (32'(phase_q) + 32'd1) >= SteerDivider;
  assign s_tready_o = (state_q == ST_IDLE) || (state_q == ST_OUT && m_tready_i);
  assign m_tvalid_o = out_v_q;
  assign cmd_o.op = (state_q == ST_RUN) ? op_q : OP_NONE;
  assign cmd_o.steer = steer_q;

  always_comb begin
    state_d = state_q;
    op_d = op_q;
    steer_d = steer_q;
    phase_d = phase_q;
    out_v_d = out_v_q;
    unique case (state_q)
      ST_IDLE, ST_OUT: begin
        if (state_q == ST_OUT && m_tready_i) begin
          out_v_d = 1'b0;
          state_d = ST_IDLE;
        end
        if (s_tvalid_i && s_tready_o) begin
          state_d = ST_RUN;
          op_d = OP_BASE;
          steer_d = fire;
          phase_d = fire ? '0 : phase_q + PhW'(1);
        end
      end
      ST_RUN: begin
        if (op_q == OP_DRIVE) begin
          state_d = ST_OUT;
          out_v_d = 1'b1;
        end else if (op_q == OP_BASE && !steer_q) begin
          op_d = OP_ERR;
        end else begin
          op_d = dp_op_e'(op_q + 4'd1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q <= OP_NONE;
      steer_q <= 1'b0;
      phase_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q <= op_d;
      steer_q <= steer_d;
      phase_q <= phase_d;
      out_v_q <= out_v_d;
    end
  end
endmodule
`default_nettype wire

// ===== sv/fsds_dp.sv =====
// Datapath: input latches, one shared 33x34 multiplier, accumulators and controller state.
// Depends on fsds_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fsds_dp (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       load_i,
  input  wire logic [63:0]                in_data_i,
  input  fsds_pkg::dp_cmd_t               cmd_i,
  input  wire logic                       cfg_we_i,
  input  wire logic [fsds_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [fsds_pkg::CfgDataW-1:0] cfg_data_i,
  output logic [47:0]                     out_data_o
);
  import fsds_pkg::*;

  logic [7:0]  set_speed_q;
  logic [15:0] yaw_slow_q, lp_q, li_q, rp_q, ri_q;

  logic signed [15:0] off_q, yaw_q, ls_q, rs_q;
  logic signed [15:0] prev_off_q;
  logic [19:0]        kp_q, kd_q, kp2_q, kd2_q;
  logic signed [23:0] tgt_l_q, tgt_r_q;
  logic signed [15:0] pe_l_q, pe_r_q, e_l_q, e_r_q;
  logic signed [15:0] acc_l_q, acc_r_q, eff_hold_q;
  logic signed [63:0] sum_q, base_q;
  logic signed [31:0] sq_q;

  logic signed [16:0] d;
  logic signed [32:0] ma;
  logic signed [33:0] mb;
  logic signed [66:0] prod;

  assign d = 17'(off_q) - 17'(prev_off_q);
  assign prod = 67'(ma) * 67'(mb);

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    if (v > 64'sd32767) return 16'sh7fff;
    if (v < -64'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    if (v > 64'sd8388607) return 24'sh7fffff;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  // Truncate toward zero divided by 2^k.
  function automatic logic signed [63:0] tdiv(input logic signed [63:0] v, input int k);
    logic signed [63:0] b;
    b = v + ((v < 0) ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0);
    return b >>> k;
  endfunction

  logic signed [63:0] eff_t;
  assign eff_t = sum_q;

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.op)
      OP_BASE:   begin ma = 33'(yaw_q[15] ? -17'(yaw_q) : 17'(yaw_q));
                   mb = 34'({1'b0, yaw_slow_q}); end
      OP_EFF_P:  begin ma = 33'(off_q); mb = 34'({1'b0, kp_q}); end
      OP_EFF_D:  begin ma = 33'(d); mb = 34'({1'b0, kd_q}); end
      OP_SQ:     begin ma = 33'(off_q[15] ? -17'(off_q) : 17'(off_q)); mb = 34'(off_q); end
      OP_EFF_P2: begin ma = 33'(sq_q); mb = 34'({1'b0, kp2_q}); end
      OP_EFF_Y:  begin ma = 33'(yaw_q); mb = 34'({1'b0, kd2_q}); end
      OP_LP:     begin ma = 33'(17'(e_l_q) - 17'(pe_l_q)); mb = 34'({1'b0, lp_q}); end
      OP_LI:     begin ma = 33'(e_l_q); mb = 34'({1'b0, li_q}); end
      OP_RP:     begin ma = 33'(17'(e_r_q) - 17'(pe_r_q)); mb = 34'({1'b0, rp_q}); end
      OP_RI:     begin ma = 33'(e_r_q); mb = 34'({1'b0, ri_q}); end
      default: ;
    endcase
  end

  logic [79:0] gs;
  logic [2:0]  sel;
  logic [1:0]  grp;
  assign sel = rule_of(band_of(17'(off_q)), band_of(d));
  assign grp = (sel >= 3'd3) ? 2'(sel - 3'd3) : 2'(3'd3 - sel);
  assign gs = gain_set(set_speed_q > 8'd70, grp);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_speed_q <= 8'd80;
      yaw_slow_q <= 16'd262;
      lp_q <= 16'd6996;
      li_q <= 16'd701;
      rp_q <= 16'd7752;
      ri_q <= 16'd977;
      prev_off_q <= '0;
      kp_q <= '0; kd_q <= '0; kp2_q <= '0; kd2_q <= '0;
      tgt_l_q <= '0; tgt_r_q <= '0;
      pe_l_q <= '0; pe_r_q <= '0;
      acc_l_q <= '0; acc_r_q <= '0;
      eff_hold_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_SET_SPEED:    set_speed_q <= cfg_data_i[7:0];
          REG_YAW_SLOWDOWN: yaw_slow_q <= cfg_data_i;
          REG_LEFT_PROP:    lp_q <= cfg_data_i;
          REG_LEFT_INT:     li_q <= cfg_data_i;
          REG_RIGHT_PROP:   rp_q <= cfg_data_i;
          REG_RIGHT_INT:    ri_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (cmd_i.op)
        OP_GAINS: begin
          if (set_speed_q <= 8'd80) begin
            {kp_q, kd_q, kp2_q, kd2_q} <= gs;
          end
        end
        OP_TARGET: begin
          prev_off_q <= off_q;
          eff_hold_q <= sat16(tdiv(eff_t, 16));
          tgt_l_q <= sat24(tdiv(base_q - eff_t, 8));
          tgt_r_q <= sat24(tdiv(base_q + eff_t, 8));
        end
        OP_DRIVE: begin
          pe_l_q <= e_l_q;
          pe_r_q <= e_r_q;
          acc_l_q <= sat16(tdiv(64'(acc_l_q) * 64'sd256 + sum_q, 8));
          acc_r_q <= sat16(tdiv(64'(acc_r_q) * 64'sd256 + base_q, 8));
        end
        default: ;
      endcase
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      off_q <= in_data_i[15:0];
      yaw_q <= in_data_i[31:16];
      ls_q <= in_data_i[47:32];
      rs_q <= in_data_i[63:48];
    end
    case (cmd_i.op)
      OP_BASE:   base_q <= 64'(set_speed_q) * 64'sd65536 - 64'(prod);
      OP_GAINS:  sum_q <= '0;
      OP_EFF_P, OP_EFF_D, OP_EFF_P2: sum_q <= sum_q + 64'(prod);
      OP_EFF_Y:  sum_q <= sum_q - 64'(prod);
      OP_SQ:     sq_q <= prod[31:0];
      OP_ERR: begin
        e_l_q <= sat16(tdiv(64'(tgt_l_q) - 64'(ls_q) * 64'sd256, 8));
        e_r_q <= sat16(tdiv(64'(tgt_r_q) - 64'(rs_q) * 64'sd256, 8));
        sum_q <= '0;
      end
      OP_LP, OP_LI: sum_q <= sum_q + 64'(prod);
      OP_RP:     base_q <= 64'(prod);
      OP_RI:     base_q <= base_q + 64'(prod);
      default: ;
    endcase
  end

  assign out_data_o = {eff_hold_q, acc_r_q, acc_l_q};
endmodule
`default_nettype wire

// ===== sv/fuzzy_steering_dual_speed_pid_unit.sv =====
// Top level of the fuzzy steering / dual wheel PI controller.
// Depends on fsds_pkg, fsds_ctrl and fsds_dp.
//
//  channel | direction | tdata (low bit up)                         | tuser
//  s_axis  | in        | lane_offset, yaw_rate, left_speed, right_speed | -
//  m_axis  | out       | left_drive, right_drive, steer_effort       | steer_updated
//  cfg     | in        | cfg_we_i, cfg_idx_i, cfg_data_i             | -
//
// A tick runs from acceptance to result as the one shared multiplier steps through the
// products in turn; a tick that is not a steering tick skips the steering steps.
// The result register is held until taken; the next tick is accepted in the
// cycle the result leaves. Reset sets defaults and clears all but payload registers.
`timescale 1ns / 1ps
`default_nettype none
module fuzzy_steering_dual_speed_pid_unit #(
  parameter int unsigned STEER_DIVIDER = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // lane_offset, yaw_rate, left_speed, right_speed
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // left_drive, right_drive, steer_effort
  output logic             m_tuser,   // steer_updated
  input  wire logic        cfg_we_i,
  input  wire logic [fsds_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [fsds_pkg::CfgDataW-1:0] cfg_data_i
);
  import fsds_pkg::*;

  dp_cmd_t cmd;
  logic    load;

  assign load = s_tvalid && s_tready;

  fsds_ctrl #(.SteerDivider(STEER_DIVIDER)) u_ctrl (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_tvalid), .s_tready_o(s_tready),
    .m_tvalid_o(m_tvalid), .m_tready_i(m_tready),
    .cmd_o(cmd)
  );

  fsds_dp u_dp (
    .clk_i, .rst_ni,
    .load_i(load), .in_data_i(s_tdata), .cmd_i(cmd),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .out_data_o(m_tdata)
  );

  assign m_tuser = cmd.steer;

  a_no_accept_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op != OP_NONE) |-> !s_tready) else $error("input accepted mid-tick");
  a_drive_then_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OP_DRIVE) |=> m_tvalid) else $error("result not presented");
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (cmd.op == OP_BASE)) else $error("tick did not start");
endmodule
`default_nettype wire

// ===== dv/fuzzy_steering_dual_speed_pid_unit_tb.sv =====
// Self-checking testbench for the fuzzy steering / dual wheel PI controller.
// Depends on fsds_pkg and fuzzy_steering_dual_speed_pid_unit; holds its own tick predictor.
`timescale 1ns / 1ps

typedef struct {
  logic signed [15:0] left_drive;
  logic signed [15:0] right_drive;
  logic signed [15:0] steer_effort;
  logic               steer_updated;
} drive_out_t;

class drive_scoreboard;
  localparam int DIVIDER = 4;

  // Gain rows {kp, kd, kp2, kd2}, Q4.16, for slow and medium set speeds.
  int unsigned slow_gains[4][4] = '{'{27525, 78643, 66, 393}, '{29491, 78643, 66, 328},
                                    '{31457, 78643, 98, 197}, '{34079, 81920, 131, 131}};
  int unsigned mid_gains[4][4] = '{'{26214, 78643, 66, 197}, '{28180, 78643, 66, 197},
                                   '{30802, 78643, 66, 197}, '{32768, 78643, 66, 66}};
  int unsigned rules[7][7] = '{'{6, 6, 6, 6, 5, 3, 3}, '{6, 6, 6, 6, 5, 3, 3},
                               '{6, 5, 5, 4, 3, 2, 1}, '{5, 5, 4, 3, 1, 1, 1},
                               '{4, 4, 3, 1, 1, 0, 6}, '{3, 3, 3, 1, 0, 0, 6},
                               '{3, 2, 0, 0, 0, 0, 0}};

  bit [7:0]    set_speed;
  bit [15:0]   yaw_slow, left_p, left_i, right_p, right_i;
  int unsigned phase;
  longint      last_offset, held_effort;
  longint      gains[4];
  longint      targets[2], last_err[2], accums[2];
  drive_out_t  expected_drives[$];
  int          mismatches, results_seen, steer_ticks;

  function new();
    set_speed = 80;
    yaw_slow = 262;
    left_p = 6996;
    left_i = 701;
    right_p = 7752;
    right_i = 977;
    phase = 0;
    last_offset = 0;
    held_effort = 0;
    foreach (gains[k]) gains[k] = 0;
    foreach (targets[k]) begin
      targets[k] = 0;
      last_err[k] = 0;
      accums[k] = 0;
    end
    mismatches = 0;
    results_seen = 0;
    steer_ticks = 0;
  endfunction

  function void write_reg(input logic [fsds_pkg::CfgIdxW-1:0] idx, input logic [15:0] val);
    case (idx)
      fsds_pkg::REG_SET_SPEED:    set_speed = val[7:0];
      fsds_pkg::REG_YAW_SLOWDOWN: yaw_slow = val;
      fsds_pkg::REG_LEFT_PROP:    left_p = val;
      fsds_pkg::REG_LEFT_INT:     left_i = val;
      fsds_pkg::REG_RIGHT_PROP:   right_p = val;
      fsds_pkg::REG_RIGHT_INT:    right_i = val;
      default: ;
    endcase
  endfunction

  function longint clamp(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function int band(input longint v);
    if (v <= -75) return 0;
    if (v <= -50) return 1;
    if (v <= -25) return 2;
    if (v <= 25) return 3;
    if (v <= 50) return 4;
    if (v <= 75) return 5;
    return 6;
  endfunction

  function longint wheel_step(input int w, input longint spd, input longint pg,
                              input longint ig);
    longint e, sum;
    e = clamp((targets[w] - spd * 256) / 256, -32768, 32767);
    sum = accums[w] * 256 + (e - last_err[w]) * pg + e * ig;
    last_err[w] = e;
    accums[w] = clamp(sum / 256, -32768, 32767);
    return accums[w];
  endfunction

  // Called on every accepted input transaction.
  function void note_tick(input logic [63:0] d);
    longint off, yaw, ls, rs, base, diff, eff;
    int sel, grp;
    drive_out_t x;
    off = longint'($signed(d[15:0]));
    yaw = longint'($signed(d[31:16]));
    ls = longint'($signed(d[47:32]));
    rs = longint'($signed(d[63:48]));
    base = longint'(set_speed) * 65536 - (yaw < 0 ? -yaw : yaw) * longint'(yaw_slow);
    x.steer_updated = 1'b0;
    if (phase + 1 >= DIVIDER) begin
      diff = off - last_offset;
      sel = rules[band(off)][band(diff)];
      grp = sel >= 3 ? sel - 3 : 3 - sel;
      phase = 0;
      x.steer_updated = 1'b1;
      steer_ticks++;
      // Above the medium band the previous gain set stays in effect.
      if (set_speed <= 70) foreach (gains[k]) gains[k] = slow_gains[grp][k];
      else if (set_speed <= 80) foreach (gains[k]) gains[k] = mid_gains[grp][k];
      eff = off * gains[0] + diff * gains[1] + (off < 0 ? -off : off) * off * gains[2]
          - yaw * gains[3];
      last_offset = off;
      held_effort = clamp(eff / 65536, -32768, 32767);
      targets[0] = clamp((base - eff) / 256, -8388608, 8388607);
      targets[1] = clamp((base + eff) / 256, -8388608, 8388607);
    end else begin
      phase = (phase + 1) & 8'hFF;
    end
    x.left_drive = 16'(wheel_step(0, ls, left_p, left_i));
    x.right_drive = 16'(wheel_step(1, rs, right_p, right_i));
    x.steer_effort = 16'(held_effort);
    expected_drives.push_back(x);
  endfunction

  function void check_drive(input logic [47:0] d, input logic upd);
    drive_out_t x;
    results_seen++;
    if (expected_drives.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result: tdata=%h tuser=%b", d, upd);
      return;
    end
    x = expected_drives.pop_front();
    if (d[15:0] !== x.left_drive || d[31:16] !== x.right_drive ||
        d[47:32] !== x.steer_effort || upd !== x.steer_updated) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch #%0d: exp L=%0d R=%0d eff=%0d upd=%b, got L=%0d R=%0d eff=%0d upd=%b",
                 results_seen, x.left_drive, x.right_drive, x.steer_effort, x.steer_updated,
                 $signed(d[15:0]), $signed(d[31:16]), $signed(d[47:32]), upd);
    end
  endfunction
endclass

module fuzzy_steering_dual_speed_pid_unit_tb;
  import fsds_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // lane_offset, yaw_rate, left_speed, right_speed
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // left_drive, right_drive, steer_effort
  logic        m_tuser;        // steer_updated
  logic        cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  drive_scoreboard board = new();
  bit  no_idle = 1'b0;
  int  cycles = 0;
  int  ticks_sent = 0;

  always #1 clk_i = ~clk_i;

  fuzzy_steering_dual_speed_pid_unit dut (
    .clk_i, .rst_ni, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .m_tuser, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // Result monitor, receiver stalls and run watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (m_tvalid && m_tready) board.check_drive(m_tdata, m_tuser);
    m_tready <= no_idle || ($urandom_range(99) >= 24);
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_tick(input logic signed [15:0] off, input logic signed [15:0] yaw,
                           input logic signed [15:0] ls, input logic signed [15:0] rs);
    if (!no_idle && $urandom_range(99) < 24) begin
      s_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 24);
    end
    s_tdata <= {rs, ls, yaw, off};
    s_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_tready);
    board.note_tick({rs, ls, yaw, off});
    ticks_sent++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    board.write_reg(idx, val);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (board.expected_drives.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick(input int narrow);
    if ($urandom_range(99) < 60) return 16'($signed($urandom_range(2 * narrow)) - narrow);
    return 16'($urandom);
  endfunction

  task automatic random_ticks(input int n);
    for (int i = 0; i < n; i++)
      send_tick(pick(120), pick(200), pick(400), pick(400));
  endtask

  initial begin
    logic signed [15:0] offs[20] = '{-32768, 32767, -75, -74, -50, -49, -25, -24, 25, 26,
                                     50, 51, 75, 76, 0, -200, 200, 0, -1, 1};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed ticks: band edges of the offset and of its change, field extremes.
    foreach (offs[i])
      send_tick(offs[i], (i % 3 == 0) ? 16'sh8000 : ((i % 3 == 1) ? 16'sh7FFF : 16'sd0),
                (i % 2) ? 16'sh7FFF : 16'sh8000, (i % 2) ? 16'sh8000 : 16'sh7FFF);
    random_ticks(180);

    for (int p = 1; p <= 5; p++) begin
      settle();
      case (p)
        1: begin
          write_reg(REG_SET_SPEED, 16'd70);
          write_reg(REG_YAW_SLOWDOWN, 16'hFFFF);
          write_reg(REG_LEFT_PROP, 16'hFFFF);
          write_reg(REG_LEFT_INT, 16'hFFFF);
          write_reg(REG_RIGHT_PROP, 16'd0);
          write_reg(REG_RIGHT_INT, 16'd0);
        end
        2: begin
          no_idle = 1'b1;
          write_reg(REG_SET_SPEED, 16'($urandom_range(80, 71)));
          write_reg(REG_YAW_SLOWDOWN, 16'($urandom));
          write_reg(REG_LEFT_PROP, 16'($urandom_range(9000)));
          write_reg(REG_LEFT_INT, 16'($urandom_range(2000)));
          write_reg(REG_RIGHT_PROP, 16'($urandom_range(9000)));
          write_reg(REG_RIGHT_INT, 16'($urandom_range(2000)));
          // Indexes past the register file must be ignored.
          write_reg(3'd6, 16'($urandom));
          write_reg(3'd7, 16'($urandom));
        end
        3: begin
          no_idle = 1'b0;
          write_reg(REG_SET_SPEED, 16'd255);
          write_reg(REG_YAW_SLOWDOWN, 16'd0);
          write_reg(REG_LEFT_PROP, 16'd0);
          write_reg(REG_LEFT_INT, 16'd300);
          write_reg(REG_RIGHT_PROP, 16'hFFFF);
          write_reg(REG_RIGHT_INT, 16'hFFFF);
        end
        4: begin
          write_reg(REG_SET_SPEED, 16'd0);
          write_reg(REG_YAW_SLOWDOWN, 16'd262);
          write_reg(REG_LEFT_PROP, 16'd6996);
          write_reg(REG_LEFT_INT, 16'd701);
          write_reg(REG_RIGHT_PROP, 16'd7752);
          write_reg(REG_RIGHT_INT, 16'd977);
        end
        default: begin
          write_reg(REG_SET_SPEED, 16'd81);
          write_reg(REG_YAW_SLOWDOWN, 16'($urandom_range(1000)));
          write_reg(REG_LEFT_PROP, 16'($urandom));
          write_reg(REG_LEFT_INT, 16'($urandom));
          write_reg(REG_RIGHT_PROP, 16'($urandom));
          write_reg(REG_RIGHT_INT, 16'($urandom));
        end
      endcase
      cfg_we_i <= 1'b0;
      @(posedge clk_i);
      random_ticks(310);
    end
    settle();

    $display("covered %0d ticks (%0d steering steps), %0d results checked over six settings",
             ticks_sent, board.steer_ticks, board.results_seen);
    $display("%0d mismatches", board.mismatches);
    if (board.mismatches == 0 && board.expected_drives.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
